// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; clock clk_i and reset rst_ni are taken from the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clock edge out of reset
`define MPVA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, checked on every clock edge out of reset
`define MPVA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/mpva_pkg.sv -----
// shared types and constants of the polyphonic voice allocator
// no dependencies
package mpva_pkg;

  // voice index field, wide enough for the largest voice count
  localparam int unsigned VIDX_W = 5;

  // message codes on the action field
  localparam logic [2:0] ACT_NOTE_ON  = 3'd0;
  localparam logic [2:0] ACT_NOTE_OFF = 3'd1;
  localparam logic [2:0] ACT_CTRL     = 3'd2;
  localparam logic [2:0] ACT_BEND     = 3'd3;
  localparam logic [2:0] ACT_PRESS    = 3'd4;

  localparam logic [6:0] CTRL_MOD_WHEEL = 7'd1;
  localparam logic [6:0] NOTE_CENTRE    = 7'd60;
  localparam logic [13:0] BEND_CENTRE   = 14'd8192;
  localparam logic [7:0] NOTE_NONE      = 8'd128;

  // registers of the configuration port
  localparam logic CFG_DEVICE_FILTER  = 1'b0;
  localparam logic CFG_CHANNEL_FILTER = 1'b1;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_ON    = 3'd1,
    OP_OFF   = 3'd2,
    OP_CTRL  = 3'd3,
    OP_BEND  = 3'd4,
    OP_PRESS = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // search record handed from cell to cell
  typedef struct packed {
    logic              free_found;
    logic [VIDX_W-1:0] free_idx;
    logic [7:0]        min_note;
    logic [VIDX_W-1:0] min_idx;
    logic              match_found;
    logic [VIDX_W-1:0] match_idx;
    logic [3:0]        match_chan;
  } scan_t;

  localparam scan_t SCAN_INIT = '{
    free_found:  1'b0,
    free_idx:    '0,
    min_note:    NOTE_NONE,
    min_idx:     '0,
    match_found: 1'b0,
    match_idx:   '0,
    match_chan:  4'd0
  };

  // voice update broadcast to all cells
  typedef struct packed {
    logic              we;
    logic              alloc;
    logic [VIDX_W-1:0] idx;
    logic [6:0]        note;
    logic [6:0]        vel;
    logic [3:0]        chan;
  } commit_t;

endpackage

// ----- rtl/mpva_cell.sv -----
// one voice cell: holds a voice and folds it into the passing search record
// depends on mpva_pkg
module mpva_cell import mpva_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wave_i,
  input  scan_t      scan_i,
  input  logic [6:0] key_i,
  input  commit_t    commit_i,
  output logic       wave_o,
  output scan_t      scan_o
);

  localparam logic [VIDX_W-1:0] MyIdx = VIDX_W'(IDX);

  logic       active_q, active_d;
  logic [6:0] note_q, note_d;
  logic [6:0] vel_q, vel_d;
  logic [3:0] chan_q, chan_d;
  logic       wave_q;
  scan_t      scan_q, scan_d;

  // fold this voice into the record
  always_comb begin
    scan_d = scan_i;
    if (!scan_i.free_found && !active_q) begin
      scan_d.free_found = 1'b1;
      scan_d.free_idx   = MyIdx;
    end
    if ({1'b0, note_q} < scan_i.min_note) begin
      scan_d.min_note = {1'b0, note_q};
      scan_d.min_idx  = MyIdx;
    end
    if (!scan_i.match_found && active_q && (note_q == key_i)) begin
      scan_d.match_found = 1'b1;
      scan_d.match_idx   = MyIdx;
      scan_d.match_chan  = chan_q;
    end
  end

  always_comb begin
    active_d = active_q;
    note_d   = note_q;
    vel_d    = vel_q;
    chan_d   = chan_q;
    if (commit_i.we && (commit_i.idx == MyIdx)) begin
      if (commit_i.alloc) begin
        active_d = 1'b1;
        note_d   = commit_i.note;
        vel_d    = commit_i.vel;
        chan_d   = commit_i.chan;
      end else begin
        active_d = 1'b0;
        note_d   = 7'd0;
        vel_d    = 7'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      note_q   <= 7'd0;
      vel_q    <= 7'd0;
      chan_q   <= 4'd0;
      wave_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      note_q   <= note_d;
      vel_q    <= vel_d;
      chan_q   <= chan_d;
      wave_q   <= wave_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wave_i) begin
      scan_q <= scan_d;
    end
  end

  assign wave_o = wave_q;
  assign scan_o = scan_q;

endmodule

// ----- rtl/midi_poly_voice_allocator.sv -----
// polyphonic midi voice allocator: lowest free voice, lowest-note steal
// note messages: result after the search wave has passed every cell (one cell a cycle)
// other messages: go from idle straight to the done state; one request in flight at a time
// next request taken in the cycle after the result loads, and none before that
// rst_ni clears all voices, global levels, filters and handshake state at once
// depends on mpva_pkg and mpva_cell
module midi_poly_voice_allocator import mpva_pkg::*; #(
  parameter int unsigned VOICES  = 8,
  parameter int unsigned DEVICES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [4:0]         cfg_data_i,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         action_i,
  input  logic [3:0]         device_index_i,
  input  logic [4:0]         channel_i,
  input  logic [6:0]         data_a_i,
  input  logic [6:0]         data_b_i,
  input  logic [13:0]        bend_value_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               passed_filter_o,
  output logic               voice_changed_o,
  output logic [2:0]         voice_number_o,
  output logic               stolen_o,
  output logic               gate_o,
  output logic signed [7:0]  pitch_semitones_o,
  output logic [6:0]         voice_velocity_o,
  output logic [4:0]         voice_midi_channel_o,
  output logic [6:0]         mod_wheel_o,
  output logic signed [13:0] pitch_bend_o,
  output logic [6:0]         aftertouch_o
);

  localparam logic [6:0] DevLimit = 7'(DEVICES);

  // filters
  logic [4:0] dev_filt_q, chan_filt_q;

  // request held while it is worked on
  state_e     state_q, state_d;
  op_e        op_q, op_d;
  logic       pass_q, pass_d;
  logic [6:0] da_q, db_q;
  logic [3:0] chan_q;
  logic [13:0] bend_q;
  logic       start_q, start_d;

  // global levels
  logic [6:0]  mod_q, mod_d;
  logic [13:0] bend_lvl_q, bend_lvl_d;
  logic [6:0]  press_q, press_d;

  // result register
  logic        out_valid_q, out_valid_d;
  logic        load;
  logic        changed_d, stolen_d, gate_d;
  logic [VIDX_W-1:0] vidx_d;
  logic [7:0]  pitch_d;
  logic [6:0]  vel_d;
  logic [4:0]  vchan_d;
  logic        pass_res_q;
  logic        changed_q, stolen_q, gate_q;
  logic [2:0]  vnum_q;
  logic [7:0]  pitch_q;
  logic [6:0]  vel_q;
  logic [4:0]  vchan_q;

  // cell chain
  logic    wave [VOICES+1];
  scan_t   scan [VOICES+1];
  commit_t commit;
  scan_t   res;

  logic accept;
  logic pass_in;
  logic [2:0] act_eff;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  // filter check and decode of the incoming request
  always_comb begin
    pass_in = 1'b1;
    if ((dev_filt_q != 5'd0) &&
        (({2'b00, dev_filt_q} > DevLimit) ||
         ({1'b0, device_index_i} != (dev_filt_q - 5'd1)))) begin
      pass_in = 1'b0;
    end
    if ((chan_filt_q != 5'd0) && (channel_i != chan_filt_q)) begin
      pass_in = 1'b0;
    end
    // note-on at zero velocity acts as note-off
    act_eff = action_i;
    if ((action_i == ACT_NOTE_ON) && (data_b_i == 7'd0)) begin
      act_eff = ACT_NOTE_OFF;
    end
    op_d = OP_NONE;
    if (pass_in) begin
      case (act_eff)
        ACT_NOTE_ON:  op_d = OP_ON;
        ACT_NOTE_OFF: op_d = OP_OFF;
        ACT_CTRL:     op_d = OP_CTRL;
        ACT_BEND:     op_d = OP_BEND;
        ACT_PRESS:    op_d = OP_PRESS;
        default:      op_d = OP_NONE;
      endcase
    end
    pass_d  = pass_in;
    start_d = accept && ((op_d == OP_ON) || (op_d == OP_OFF));
  end

  // sequencer: idle, wait for the search wave on note messages, then commit
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = start_d ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (wave[VOICES]) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commit stage, result register free or being emptied
  assign load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign res  = scan[VOICES];

  always_comb begin
    commit     = '0;
    changed_d  = 1'b0;
    stolen_d   = 1'b0;
    gate_d     = 1'b0;
    vidx_d     = '0;
    pitch_d    = 8'd0;
    vel_d      = 7'd0;
    vchan_d    = 5'd0;
    mod_d      = mod_q;
    bend_lvl_d = bend_lvl_q;
    press_d    = press_q;
    case (op_q)
      OP_ON: begin
        // first free voice, else steal the lowest note
        vidx_d    = res.free_found ? res.free_idx : res.min_idx;
        stolen_d  = !res.free_found;
        changed_d = 1'b1;
        gate_d    = 1'b1;
        pitch_d   = {1'b0, da_q} - {1'b0, NOTE_CENTRE};
        vel_d     = db_q;
        vchan_d   = {1'b0, chan_q} + 5'd1;
        commit.we    = load;
        commit.alloc = 1'b1;
        commit.idx   = vidx_d;
        commit.note  = da_q;
        commit.vel   = db_q;
        commit.chan  = chan_q;
      end
      OP_OFF: begin
        if (res.match_found) begin
          vidx_d    = res.match_idx;
          changed_d = 1'b1;
          vchan_d   = {1'b0, res.match_chan} + 5'd1;
          commit.we    = load;
          commit.alloc = 1'b0;
          commit.idx   = res.match_idx;
        end
      end
      OP_CTRL: begin
        if (da_q == CTRL_MOD_WHEEL) begin
          mod_d = db_q;
        end
      end
      OP_BEND:  bend_lvl_d = bend_q - BEND_CENTRE;
      OP_PRESS: press_d    = da_q;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // the chain of voice cells
  assign wave[0] = start_q;
  assign scan[0] = SCAN_INIT;

  for (genvar g = 0; g < VOICES; g++) begin : g_cell
    mpva_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wave_i   (wave[g]),
      .scan_i   (scan[g]),
      .key_i    (da_q),
      .commit_i (commit),
      .wave_o   (wave[g+1]),
      .scan_o   (scan[g+1])
    );
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      dev_filt_q  <= 5'd0;
      chan_filt_q <= 5'd0;
      mod_q       <= 7'd0;
      bend_lvl_q  <= 14'd0;
      press_q     <= 7'd0;
      op_q        <= OP_NONE;
      pass_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DEVICE_FILTER:  dev_filt_q  <= cfg_data_i;
          CFG_CHANNEL_FILTER: chan_filt_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (load) begin
        mod_q      <= mod_d;
        bend_lvl_q <= bend_lvl_d;
        press_q    <= press_d;
      end
      if (accept) begin
        op_q   <= op_d;
        pass_q <= pass_d;
      end
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      da_q   <= data_a_i;
      db_q   <= data_b_i;
      chan_q <= 4'(channel_i - 5'd1);
      bend_q <= bend_value_i;
    end
  end

  // result payload, held while the result waits even if a new request is taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      pass_res_q <= pass_q;
      changed_q  <= changed_d;
      stolen_q   <= stolen_d;
      gate_q     <= gate_d;
      vnum_q     <= vidx_d[2:0];
      pitch_q    <= pitch_d;
      vel_q      <= vel_d;
      vchan_q    <= vchan_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign passed_filter_o      = pass_res_q;
  assign voice_changed_o      = changed_q;
  assign voice_number_o       = vnum_q;
  assign stolen_o             = stolen_q;
  assign gate_o               = gate_q;
  assign pitch_semitones_o    = $signed(pitch_q);
  assign voice_velocity_o     = vel_q;
  assign voice_midi_channel_o = vchan_q;
  assign mod_wheel_o          = mod_q;
  assign pitch_bend_o         = $signed(bend_lvl_q);
  assign aftertouch_o         = press_q;

endmodule

// ----- rtl/mpva_checker.sv -----
// port-level checks of the voice allocator, bound to the top level
// depends on assert_macros.svh and midi_poly_voice_allocator
`include "assert_macros.svh"

module mpva_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic               cfg_index_i,
  input logic [4:0]         cfg_data_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [2:0]         action_i,
  input logic [3:0]         device_index_i,
  input logic [4:0]         channel_i,
  input logic [6:0]         data_a_i,
  input logic [6:0]         data_b_i,
  input logic [13:0]        bend_value_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               passed_filter_o,
  input logic               voice_changed_o,
  input logic [2:0]         voice_number_o,
  input logic               stolen_o,
  input logic               gate_o,
  input logic signed [7:0]  pitch_semitones_o,
  input logic [6:0]         voice_velocity_o,
  input logic [4:0]         voice_midi_channel_o,
  input logic [6:0]         mod_wheel_o,
  input logic signed [13:0] pitch_bend_o,
  input logic [6:0]         aftertouch_o
);

  // one request in flight: a taken request closes the input
  `MPVA_ASSERT_NXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o)

  // a stalled result keeps its voice fields
  `MPVA_ASSERT_NXT(a_result_holds, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(voice_number_o) && $stable(pitch_semitones_o))

  // a steal is always a new allocation of a voice that passed the filter
  `MPVA_ASSERT_IMP(a_steal_alloc, out_valid_o && stolen_o,
                   voice_changed_o && gate_o && passed_filter_o)

  // a released or untouched voice reports no pitch and no velocity
  `MPVA_ASSERT_IMP(a_release_clear, out_valid_o && !gate_o,
                   (pitch_semitones_o == 8'sd0) && (voice_velocity_o == 7'd0) && !stolen_o)

endmodule

bind midi_poly_voice_allocator mpva_checker u_mpva_checker (.*);
